FILE: design/pctd_pkg.sv
// shared types, constants and hex helpers for the percent decoder
package pctd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam int         MAX_OUT    = 3;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

    // up to three decoded bytes produced by one input item
    typedef struct packed {
        logic [1:0]             cnt;
        logic                   last;
        logic [MAX_OUT-1:0][7:0] bytes;
    } pctd_bundle_t;

    typedef struct packed {
        logic         push;
        pctd_bundle_t bundle;
    } pctd_wr_t;

    typedef struct packed {
        logic idle;
    } pctd_front_stat_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            // 'a'/'A' have low nibble 1
            v = c[3:0] - 4'd1 + HEX_ALPHA_BASE;
        end
        return v;
    endfunction

endpackage

FILE: design/pctd_front.sv
// front end: takes input items, tracks escape state, builds output bundles
module pctd_front import pctd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             in_fire,
    output pctd_wr_t         wr,
    output pctd_front_stat_t stat
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    pctd_bundle_t bnd;
    logic       hex;

    assign hex = is_hex(in_byte);

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        bnd        = '0;
        bnd.last   = in_last;
        case (phase_reg)
            PH_PCT: begin
                if (hex) begin
                    if (in_last) begin
                        bnd.bytes[0] = PCT_CHAR;
                        bnd.bytes[1] = in_byte;
                        bnd.cnt      = 2'd2;
                        phase_next   = PH_IDLE;
                    end else begin
                        held_next  = in_byte;
                        phase_next = PH_DIGIT;
                    end
                end else begin
                    bnd.bytes[0] = PCT_CHAR;
                    if (in_byte == PCT_CHAR && !in_last) begin
                        bnd.cnt    = 2'd1;
                        phase_next = PH_PCT;
                    end else begin
                        bnd.bytes[1] = in_byte;
                        bnd.cnt      = 2'd2;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            PH_DIGIT: begin
                if (hex) begin
                    bnd.bytes[0] = {hex_val(held_reg), hex_val(in_byte)};
                    bnd.cnt      = 2'd1;
                    phase_next   = PH_IDLE;
                end else begin
                    bnd.bytes[0] = PCT_CHAR;
                    bnd.bytes[1] = held_reg;
                    if (in_byte == PCT_CHAR && !in_last) begin
                        bnd.cnt    = 2'd2;
                        phase_next = PH_PCT;
                    end else begin
                        bnd.bytes[2] = in_byte;
                        bnd.cnt      = 2'd3;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            default: begin
                if (in_byte == PCT_CHAR && !in_last) begin
                    phase_next = PH_PCT;
                end else begin
                    bnd.bytes[0] = in_byte;
                    bnd.cnt      = 2'd1;
                    phase_next   = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // items that only open an escape leave nothing to queue
    assign wr.push   = in_fire && (bnd.cnt != 2'd0);
    assign wr.bundle = bnd;
    assign stat.idle = (phase_reg == PH_IDLE);

endmodule

FILE: design/pctd_fifo.sv
// short register queue of output bundles between front and back
module pctd_fifo import pctd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  pctd_wr_t          wr,
    input  logic              rd_en,
    output logic              full,
    output logic              rd_valid,
    output pctd_bundle_t      rd_data,
    output logic [QCNT_W-1:0] count
);

    pctd_bundle_t      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign count    = cnt_reg;
    assign do_pop   = rd_en && rd_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (wr.push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!wr.push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.push) begin
            mem_reg[wptr_reg] <= wr.bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (wr.push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/pctd_back.sv
// back end: unpacks bundles into single output items behind a register
module pctd_back import pctd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         rd_valid,
    input  pctd_bundle_t rd_data,
    output logic         rd_en,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load, at_end;

    assign load   = rd_valid && (!valid_reg || m_tready);
    assign at_end = (idx_reg == rd_data.cnt - 2'd1);
    assign rd_en  = load && at_end;
    assign idx_next = at_end ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= rd_data.bytes[idx_reg];
            last_reg <= rd_data.last && at_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: design/percent_decoder.sv
// top level of the streaming url percent decoder
//
// input channel s_*: one raw byte per item in s_tdata, s_tlast on the final
// byte of a string. output channel m_*: one decoded byte per item in m_tdata,
// m_tlast on the final decoded byte of the string.
// an item with a valid %xx escape yields one output byte on its second digit;
// a broken or cut-off escape yields up to three bytes from one item.
// an accepted input item reaches the output through the bundle queue, then
// the output register. the input takes one item per cycle while the
// four-entry bundle queue has room; the output side moves one byte per cycle
// while m_tready is high, the pace being set by the output register.
// when m_tready is low the output register holds, the queue fills and
// s_tready drops once all four entries are occupied.
// reset (aresetn low, synchronous) empties the queue, clears the output
// valid flag and drops any partly received escape.
module percent_decoder import pctd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast
);

    pctd_wr_t          wr;
    pctd_front_stat_t  fstat;
    pctd_bundle_t      rd_data;
    logic              rd_valid, rd_en, full, s_fire;
    logic [QCNT_W-1:0] q_count;

    assign s_tready = !full;
    assign s_fire   = s_tvalid && s_tready;

    pctd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .in_fire (s_fire),
        .wr      (wr),
        .stat    (fstat)
    );

    pctd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd_en    (rd_en),
        .full     (full),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .count    (q_count)
    );

    pctd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // end of string always leaves the escape tracker idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> fstat.idle)
        else $error("escape state pending after last item");

    // the queue never takes a bundle when full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.push |-> q_count < QCNT_W'(QUEUE_DEPTH))
        else $error("bundle queue overflow");

    // nothing is presented right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && q_count == '0)
        else $error("output valid after reset");

    // queued bundles never carry zero bytes
    a_bundle_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid |-> rd_data.cnt != 2'd0)
        else $error("empty bundle in queue");

endmodule
